// ===== rtl/ttbd_pkg.sv =====
// ============================================================================
// ttbd_pkg: shared types and constants of the temporal-three beep detector
// Phase codes, configuration register indexes, the configuration bundle and
// the classified sample that travels from the front end to the back end.
// ============================================================================
`default_nettype none

package ttbd_pkg;

    // Widths fixed by the field definitions
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int CYCLE_W  = 4;
    localparam int BCOUNT_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Saturation limit of the confirmed-cycle count
    localparam logic [CYCLE_W-1:0] CYCLE_MAX = '1;

    // Phase codes
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BEEP  = 2'd1,
        PH_GAP   = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_LEN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_TOL   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TOL    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LEN  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TOL  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLES     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE    = 8'd7;

    // Configuration bundle
    typedef struct packed {
        logic [LEN_W-1:0]   beep_length_ms;
        logic [LEN_W-1:0]   beep_tolerance_ms;
        logic [LEN_W-1:0]   gap_length_ms;
        logic [LEN_W-1:0]   gap_tolerance_ms;
        logic [LEN_W-1:0]   pause_length_ms;
        logic [LEN_W-1:0]   pause_tolerance_ms;
        logic [CYCLE_W-1:0] cycles_needed;
        logic [LEN_W-1:0]   quiet_limit_ms;
    } cfg_t;

    // Classified sample handed from front end to back end
    typedef struct packed {
        logic              rising;
        logic              falling;
        logic              timeout;
        logic [TIME_W-1:0] time_ms;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/temporal_three_beep_detector_unit.sv =====
// ============================================================================
// temporal_three_beep_detector_unit: temporal-three alarm pattern detector
// Front end classifies beep samples, a short queue decouples it from the
// back end, which runs the phase machine and reports one result per sample.
// ============================================================================
// Takes one beep sample per clock while in_ready is high and returns one
// result per sample, in order. A sample accepted into the queue is stepped
// by the back end once it reaches the head and the result register is free;
// its result is then registered there and held until taken. The sustained
// rate is one sample per cycle while the output is not stalled, set by the
// phase update in the back end. While the output is stalled the result
// register holds one sample and the queue QUEUE_DEPTH more, so input keeps
// flowing for QUEUE_DEPTH + 1 samples before in_ready drops. Write the
// configuration registers only while no sample is in flight.
`default_nettype none

module temporal_three_beep_detector_unit
    import ttbd_pkg::*;
#(
    parameter int BEEPS_IN_CYCLE = 3,
    parameter int QUEUE_DEPTH    = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  beep_on,
    input  wire logic [TIME_W-1:0]     time_ms,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       pattern_detected,
    output logic [1:0]                 phase,
    output logic [CYCLE_W-1:0]         cycles_seen
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    item_t front_item;
    item_t head_item;
    logic  in_accept;
    logic  q_full;
    logic  q_empty;
    logic  step;

    // Update the addressed configuration register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BEEP_LEN:  cfg_next.beep_length_ms     = cfg_data;
                REG_BEEP_TOL:  cfg_next.beep_tolerance_ms  = cfg_data;
                REG_GAP_LEN:   cfg_next.gap_length_ms      = cfg_data;
                REG_GAP_TOL:   cfg_next.gap_tolerance_ms   = cfg_data;
                REG_PAUSE_LEN: cfg_next.pause_length_ms    = cfg_data;
                REG_PAUSE_TOL: cfg_next.pause_tolerance_ms = cfg_data;
                REG_CYCLES:    cfg_next.cycles_needed      = cfg_data[CYCLE_W-1:0];
                REG_SILENCE:   cfg_next.quiet_limit_ms     = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beep_length_ms     <= 16'd500;
            cfg_reg.beep_tolerance_ms  <= 16'd150;
            cfg_reg.gap_length_ms      <= 16'd500;
            cfg_reg.gap_tolerance_ms   <= 16'd150;
            cfg_reg.pause_length_ms    <= 16'd1500;
            cfg_reg.pause_tolerance_ms <= 16'd300;
            cfg_reg.cycles_needed      <= 4'd2;
            cfg_reg.quiet_limit_ms     <= 16'd5000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a request whenever the queue has room
    assign in_ready  = ~q_full;
    assign in_accept = in_valid & ~q_full;

    ttbd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .beep_on        (beep_on),
        .time_ms        (time_ms),
        .quiet_limit_ms (cfg_reg.quiet_limit_ms),
        .item           (front_item)
    );

    ttbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (step),
        .empty     (q_empty),
        .head      (head_item)
    );

    // Step the back end when a sample waits and the result stage is free
    assign step = ~q_empty & (~out_valid | out_ready);

    ttbd_back #(
        .BEEPS_IN_CYCLE (BEEPS_IN_CYCLE)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .step             (step),
        .item             (head_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pattern_detected (pattern_detected),
        .phase            (phase),
        .cycles_seen      (cycles_seen)
    );

endmodule

`default_nettype wire

// ===== rtl/ttbd_front.sv =====
// ============================================================================
// ttbd_front: sample classifier
// Tracks the previous beep level and the last beep time, and tags each sample
// with its rising edge, falling edge and silence-timeout condition.
// ============================================================================
`default_nettype none

module ttbd_front
    import ttbd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic                beep_on,
    input  wire logic [TIME_W-1:0]   time_ms,
    input  wire logic [LEN_W-1:0]    quiet_limit_ms,
    output item_t                    item
);

    logic              prev_beep_reg;
    logic              prev_beep_next;
    logic [TIME_W-1:0] last_beep_time_reg;
    logic [TIME_W-1:0] last_beep_time_next;
    logic [TIME_W-1:0] silence_ms;

    // Refresh the last beep time, then measure the silence since it
    always_comb
    begin
        last_beep_time_next = beep_on ? time_ms : last_beep_time_reg;
        prev_beep_next      = beep_on;
        silence_ms          = time_ms - last_beep_time_next;
    end

    // Classify the sample
    always_comb
    begin
        item.rising  = beep_on & ~prev_beep_reg;
        item.falling = ~beep_on & prev_beep_reg;
        item.timeout = silence_ms > {{(TIME_W-LEN_W){1'b0}}, quiet_limit_ms};
        item.time_ms = time_ms;
    end

    // Advance the edge tracker on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_beep_reg      <= 1'b0;
            last_beep_time_reg <= '0;
        end
        else if (accept)
        begin
            prev_beep_reg      <= prev_beep_next;
            last_beep_time_reg <= last_beep_time_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttbd_queue.sv =====
// ============================================================================
// ttbd_queue: short register queue between front end and back end
// Holds classified samples so either side can stall on its own; a push and a
// pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module ttbd_queue
    import ttbd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Status and head of the queue
    always_comb
    begin
        full  = count_reg == CNT_W'(DEPTH);
        empty = count_reg == '0;
        head  = slot_reg[rd_ptr_reg];
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttbd_back.sv =====
// ============================================================================
// ttbd_back: phase machine and duration checker
// Takes one sample per cycle when stepped, checks beep, gap and pause lengths,
// counts confirmed cycles and holds the result registers for the output.
// ============================================================================
`default_nettype none

module ttbd_back
    import ttbd_pkg::*;
#(
    parameter int BEEPS_IN_CYCLE = 3
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 step,
    input  wire item_t                item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      pattern_detected,
    output logic [1:0]                phase,
    output logic [CYCLE_W-1:0]        cycles_seen
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [BCOUNT_W-1:0] beep_count_reg;
    logic [BCOUNT_W-1:0] beep_count_next;
    logic [CYCLE_W-1:0]  cycle_count_reg;
    logic [CYCLE_W-1:0]  cycle_count_next;
    logic                detected_reg;
    logic                detected_next;
    logic [TIME_W-1:0]   edge_time_reg;
    logic [TIME_W-1:0]   edge_time_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // State after a silence timeout has been applied
    logic                clear_to;
    phase_t              phase_eff;
    logic [BCOUNT_W-1:0] beep_count_eff;
    logic [CYCLE_W-1:0]  cycle_count_eff;
    logic                detected_eff;

    // Duration check
    logic [TIME_W-1:0]   elapsed;
    logic [LEN_W-1:0]    target;
    logic [LEN_W-1:0]    tol;
    logic [TIME_W:0]     elapsed_plus_tol;
    logic [LEN_W:0]      target_plus_tol;
    logic                fit;

    logic [BCOUNT_W-1:0] beep_count_inc;
    logic [CYCLE_W-1:0]  cycle_count_inc;

    // Drop a detected attempt on a silence timeout
    always_comb
    begin
        clear_to        = detected_reg & item.timeout;
        phase_eff       = clear_to ? PH_IDLE : phase_reg;
        beep_count_eff  = clear_to ? '0 : beep_count_reg;
        cycle_count_eff = clear_to ? '0 : cycle_count_reg;
        detected_eff    = clear_to ? 1'b0 : detected_reg;
    end

    // Check the elapsed time against the target of the current phase
    always_comb
    begin
        elapsed = item.time_ms - edge_time_reg;
        unique case (phase_eff)
            PH_BEEP:
            begin
                target = cfg.beep_length_ms;
                tol    = cfg.beep_tolerance_ms;
            end
            PH_GAP:
            begin
                target = cfg.gap_length_ms;
                tol    = cfg.gap_tolerance_ms;
            end
            PH_PAUSE:
            begin
                target = cfg.pause_length_ms;
                tol    = cfg.pause_tolerance_ms;
            end
            default:
            begin
                target = cfg.beep_length_ms;
                tol    = cfg.beep_tolerance_ms;
            end
        endcase
        elapsed_plus_tol = {1'b0, elapsed} + {{(TIME_W-LEN_W+1){1'b0}}, tol};
        target_plus_tol  = {1'b0, target} + {1'b0, tol};
        fit = (elapsed_plus_tol >= {{(TIME_W-LEN_W+1){1'b0}}, target})
            && ({1'b0, elapsed} <= {{(TIME_W-LEN_W){1'b0}}, target_plus_tol});
    end

    always_comb
    begin
        beep_count_inc  = beep_count_eff + 1'b1;
        cycle_count_inc = (cycle_count_eff == CYCLE_MAX) ? CYCLE_MAX
                                                        : cycle_count_eff + 1'b1;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_IDLE:
                begin
                    if (item.rising)
                    begin
                        phase_next = PH_BEEP;
                    end
                end
                PH_BEEP:
                begin
                    if (item.falling)
                    begin
                        if (!fit)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (beep_count_inc < BCOUNT_W'(BEEPS_IN_CYCLE))
                        begin
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            phase_next = PH_PAUSE;
                        end
                    end
                end
                PH_GAP:
                begin
                    if (item.rising)
                    begin
                        phase_next = PH_BEEP;
                    end
                end
                PH_PAUSE:
                begin
                    if (item.rising)
                    begin
                        phase_next = PH_BEEP;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Counters, detection flag and edge time
    always_comb
    begin
        beep_count_next  = beep_count_reg;
        cycle_count_next = cycle_count_reg;
        detected_next    = detected_reg;
        edge_time_next   = edge_time_reg;
        if (step)
        begin
            beep_count_next  = beep_count_eff;
            cycle_count_next = cycle_count_eff;
            detected_next    = detected_eff;
            unique case (phase_eff)
                PH_IDLE:
                begin
                    if (item.rising)
                    begin
                        edge_time_next = item.time_ms;
                    end
                end
                PH_BEEP:
                begin
                    if (item.falling)
                    begin
                        if (!fit)
                        begin
                            beep_count_next  = '0;
                            cycle_count_next = '0;
                            detected_next    = 1'b0;
                        end
                        else
                        begin
                            beep_count_next = beep_count_inc;
                            edge_time_next  = item.time_ms;
                        end
                    end
                end
                PH_GAP:
                begin
                    if (item.rising)
                    begin
                        if (!fit)
                        begin
                            beep_count_next  = '0;
                            cycle_count_next = '0;
                            detected_next    = 1'b0;
                        end
                        edge_time_next = item.time_ms;
                    end
                end
                PH_PAUSE:
                begin
                    if (item.rising)
                    begin
                        if (!fit)
                        begin
                            beep_count_next  = '0;
                            cycle_count_next = '0;
                            detected_next    = 1'b0;
                        end
                        else
                        begin
                            beep_count_next  = '0;
                            cycle_count_next = cycle_count_inc;
                            if (cycle_count_inc >= cfg.cycles_needed)
                            begin
                                detected_next = 1'b1;
                            end
                        end
                        edge_time_next = item.time_ms;
                    end
                end
                default:
                begin
                    edge_time_next = edge_time_reg;
                end
            endcase
        end
    end

    // Output handshake: a stepped request produces one result
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            beep_count_reg  <= '0;
            cycle_count_reg <= '0;
            detected_reg    <= 1'b0;
            edge_time_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            beep_count_reg  <= beep_count_next;
            cycle_count_reg <= cycle_count_next;
            detected_reg    <= detected_next;
            edge_time_reg   <= edge_time_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result registers double as the output stage
    assign out_valid        = out_valid_reg;
    assign pattern_detected = detected_reg;
    assign phase            = phase_reg;
    assign cycles_seen      = cycle_count_reg;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for the temporal-three beep detector
// Drives beep samples with timestamps through the request channel, predicts
// each status result with an in-bench model of the phase machine, and checks
// every result in order, under several register settings and random idling.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int BEEPS        = 3;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 300;
    localparam int REG_COUNT    = 8;

    // One status result: detection flag, phase and confirmed cycles
    typedef struct packed {
        logic               detected;
        phase_t             ph;
        logic [CYCLE_W-1:0] cycles;
    } status_t;

    // Block ports
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  beep_on      = 1'b0;
    logic [TIME_W-1:0]     time_ms      = '0;
    logic                  out_ready    = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  pattern_detected;
    logic [1:0]            phase;
    logic [CYCLE_W-1:0]    cycles_seen;

    // Detector model state and its copy of the registers
    cfg_t                  mdl_cfg;
    phase_t                mdl_phase;
    logic [BCOUNT_W-1:0]   mdl_beeps;
    logic [CYCLE_W-1:0]    mdl_cycles;
    logic                  mdl_detected;
    logic                  mdl_prev;
    logic [TIME_W-1:0]     mdl_last_beep;
    logic [TIME_W-1:0]     mdl_edge;

    // Expected status results, oldest first
    status_t               expected_status[$];

    // Stimulus control
    logic [TIME_W-1:0]     now_ms       = '0;
    bit                    only_good    = 1'b0;
    bit                    src_gaps_on  = 1'b1;
    bit                    sink_gaps_on = 1'b1;
    int unsigned           hold_request = 0;

    // Bookkeeping
    int unsigned           errors          = 0;
    int unsigned           samples_sent    = 0;
    int unsigned           results_checked = 0;
    int unsigned           settings_used   = 1;
    int unsigned           detect_events   = 0;
    int unsigned           silence_clears  = 0;
    int unsigned           saturated_steps = 0;
    int unsigned           cycles_run      = 0;

    temporal_three_beep_detector_unit #(
        .BEEPS_IN_CYCLE (BEEPS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .beep_on          (beep_on),
        .time_ms          (time_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pattern_detected (pattern_detected),
        .phase            (phase),
        .cycles_seen      (cycles_seen)
    );

    // Clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d results still pending",
                     $time, cycles_run, expected_status.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Detector model
    // ------------------------------------------------------------------------

    function automatic cfg_t default_config();
        cfg_t c;
        c.beep_length_ms     = 16'd500;
        c.beep_tolerance_ms  = 16'd150;
        c.gap_length_ms      = 16'd500;
        c.gap_tolerance_ms   = 16'd150;
        c.pause_length_ms    = 16'd1500;
        c.pause_tolerance_ms = 16'd300;
        c.cycles_needed      = 4'd2;
        c.quiet_limit_ms     = 16'd5000;
        return c;
    endfunction

    function automatic void clear_attempt();
        mdl_phase    = PH_IDLE;
        mdl_beeps    = '0;
        mdl_cycles   = '0;
        mdl_detected = 1'b0;
    endfunction

    function automatic void reset_model();
        mdl_cfg       = default_config();
        clear_attempt();
        mdl_prev      = 1'b0;
        mdl_last_beep = '0;
        mdl_edge      = '0;
    endfunction

    // Window check at 33 bits so neither sum can overflow
    function automatic bit in_window(input logic [TIME_W-1:0] elapsed,
                                     input logic [LEN_W-1:0] target,
                                     input logic [LEN_W-1:0] tol);
        logic [TIME_W:0] e_wide;
        logic [TIME_W:0] low_sum;
        logic [TIME_W:0] high_sum;
        e_wide   = {1'b0, elapsed};
        low_sum  = e_wide + tol;
        high_sum = {{(TIME_W+1-LEN_W){1'b0}}, target} + tol;
        return (low_sum >= target) && (e_wide <= high_sum);
    endfunction

    // Advance the model by one sample and return the status it reports
    function automatic status_t predict_status(input logic beep,
                                               input logic [TIME_W-1:0] stamp);
        logic              rise;
        logic              fall;
        logic [TIME_W-1:0] since;
        status_t           s;

        if (beep)
            mdl_last_beep = stamp;
        since = stamp - mdl_last_beep;
        if (mdl_detected && since > mdl_cfg.quiet_limit_ms)
        begin
            clear_attempt();
            silence_clears++;
        end

        rise     = beep && !mdl_prev;
        fall     = !beep && mdl_prev;
        mdl_prev = beep;
        since    = stamp - mdl_edge;

        case (mdl_phase)
            PH_IDLE:
            begin
                if (rise)
                begin
                    mdl_phase = PH_BEEP;
                    mdl_edge  = stamp;
                end
            end
            PH_BEEP:
            begin
                if (fall)
                begin
                    if (!in_window(since, mdl_cfg.beep_length_ms, mdl_cfg.beep_tolerance_ms))
                        clear_attempt();
                    else
                    begin
                        mdl_beeps = mdl_beeps + 1'b1;
                        mdl_edge  = stamp;
                        mdl_phase = (mdl_beeps < BEEPS) ? PH_GAP : PH_PAUSE;
                    end
                end
            end
            PH_GAP:
            begin
                // a bad gap restarts, and the same edge opens a fresh beep
                if (rise)
                begin
                    if (!in_window(since, mdl_cfg.gap_length_ms, mdl_cfg.gap_tolerance_ms))
                        clear_attempt();
                    mdl_edge  = stamp;
                    mdl_phase = PH_BEEP;
                end
            end
            default:
            begin
                if (rise)
                begin
                    if (!in_window(since, mdl_cfg.pause_length_ms,
                                   mdl_cfg.pause_tolerance_ms))
                        clear_attempt();
                    else
                    begin
                        if (mdl_cycles != CYCLE_MAX)
                            mdl_cycles = mdl_cycles + 1'b1;
                        mdl_beeps = '0;
                        if (mdl_cycles >= mdl_cfg.cycles_needed)
                        begin
                            if (!mdl_detected)
                                detect_events++;
                            mdl_detected = 1'b1;
                        end
                    end
                    mdl_edge  = stamp;
                    mdl_phase = PH_BEEP;
                end
            end
        endcase

        if (mdl_cycles == CYCLE_MAX)
            saturated_steps++;
        s.detected = mdl_detected;
        s.ph       = mdl_phase;
        s.cycles   = mdl_cycles;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Request and result sides
    // ------------------------------------------------------------------------

    // Offer one sample, optionally after an idle burst; return once accepted
    task automatic send_sample(input logic beep, input logic [TIME_W-1:0] stamp);
        int unsigned gap;
        @(negedge clk);
        if (src_gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        beep_on  <= beep;
        time_ms  <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        expected_status.push_back(predict_status(beep, stamp));
        samples_sent++;
    endtask

    // Drop the request and wait until every result is back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Result-side ready: random stall bursts plus the long hold-off
    initial
    begin : sink_side
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("[%0t] result with nothing expected: detected=%0b phase=%0d cycles=%0d",
                         $time, pattern_detected, phase, cycles_seen);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (pattern_detected !== want.detected)
                begin
                    $display("[%0t] pattern_detected: expected %0b, got %0b",
                             $time, want.detected, pattern_detected);
                    errors++;
                end
                if (phase !== want.ph)
                begin
                    $display("[%0t] phase: expected %0d, got %0d", $time, want.ph, phase);
                    errors++;
                end
                if (cycles_seen !== want.cycles)
                begin
                    $display("[%0t] cycles_seen: expected %0d, got %0d",
                             $time, want.cycles, cycles_seen);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------------

    // Write one register at the current falling edge and mirror it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        case (idx)
            REG_BEEP_LEN:  mdl_cfg.beep_length_ms     = data;
            REG_BEEP_TOL:  mdl_cfg.beep_tolerance_ms  = data;
            REG_GAP_LEN:   mdl_cfg.gap_length_ms      = data;
            REG_GAP_TOL:   mdl_cfg.gap_tolerance_ms   = data;
            REG_PAUSE_LEN: mdl_cfg.pause_length_ms    = data;
            REG_PAUSE_TOL: mdl_cfg.pause_tolerance_ms = data;
            REG_CYCLES:    mdl_cfg.cycles_needed      = data[CYCLE_W-1:0];
            REG_SILENCE:   mdl_cfg.quiet_limit_ms     = data;
            default: ;
        endcase
    endtask

    // Load a full setting while idle; junk in the upper bits of the cycle
    // register and writes to unused indexes must change nothing
    task automatic apply_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom());
        write_reg(REG_BEEP_LEN,  c.beep_length_ms);
        write_reg(REG_BEEP_TOL,  c.beep_tolerance_ms);
        write_reg(REG_GAP_LEN,   c.gap_length_ms);
        write_reg(REG_GAP_TOL,   c.gap_tolerance_ms);
        write_reg(REG_PAUSE_LEN, c.pause_length_ms);
        write_reg(REG_PAUSE_TOL, c.pause_tolerance_ms);
        write_reg(REG_CYCLES,    {junk[CFG_DATA_W-1:CYCLE_W], c.cycles_needed});
        write_reg(REG_SILENCE,   c.quiet_limit_ms);
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_COUNT)),
                  CFG_DATA_W'($urandom()));
        write_reg('1, CFG_DATA_W'($urandom()));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic cfg_t random_config(input bit wide);
        cfg_t        c;
        int unsigned len_max;
        int unsigned tol_max;
        len_max = wide ? 65535 : 2500;
        tol_max = wide ? 65535 : 400;
        c.beep_length_ms     = LEN_W'($urandom_range(len_max, 0));
        c.beep_tolerance_ms  = LEN_W'($urandom_range(tol_max, 0));
        c.gap_length_ms      = LEN_W'($urandom_range(len_max, 0));
        c.gap_tolerance_ms   = LEN_W'($urandom_range(tol_max, 0));
        c.pause_length_ms    = LEN_W'($urandom_range(len_max, 0));
        c.pause_tolerance_ms = LEN_W'($urandom_range(tol_max, 0));
        c.cycles_needed      = CYCLE_W'($urandom_range(15, 1));
        c.quiet_limit_ms     = LEN_W'($urandom_range(wide ? 65535 : 8000, 0));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Pattern generation
    // ------------------------------------------------------------------------

    // Pick a duration: mostly inside the window, some at its edges, some wild
    function automatic logic [TIME_W-1:0] pick_span(input logic [LEN_W-1:0] target,
                                                    input logic [LEN_W-1:0] tol);
        int unsigned lo;
        int unsigned hi;
        int unsigned roll;
        hi   = target + tol;
        lo   = (target > tol) ? target - tol : 0;
        roll = $urandom_range(0, 99);
        if (only_good || roll < 72)
            return $urandom_range(hi, lo);
        if (roll < 88)
        begin
            case ($urandom_range(0, 3))
                0:       return lo;
                1:       return hi;
                2:       return hi + 1;
                default: return (lo == 0) ? 0 : lo - 1;
            endcase
        end
        return $urandom_range(2 * hi + 64, 0);
    endfunction

    // Hold one level for dur ms: a sample at the edge, a few inside
    task automatic gen_span(input logic level, input logic [TIME_W-1:0] dur,
                            input int unsigned extra_max);
        logic [TIME_W-1:0] pos;
        int unsigned       extra;
        send_sample(level, now_ms);
        pos   = '0;
        extra = $urandom_range(0, extra_max);
        repeat (extra)
        begin
            if (dur > pos + 1)
            begin
                pos = pos + 1 + ($urandom() % (dur - pos - 1));
                send_sample(level, now_ms + pos);
            end
        end
        now_ms = now_ms + dur;
    endtask

    // Three beeps, two gaps and the closing pause
    task automatic gen_cycle();
        for (int b = 0; b < BEEPS; b++)
        begin
            gen_span(1'b1, pick_span(mdl_cfg.beep_length_ms, mdl_cfg.beep_tolerance_ms), 2);
            if (b < BEEPS - 1)
                gen_span(1'b0, pick_span(mdl_cfg.gap_length_ms, mdl_cfg.gap_tolerance_ms), 2);
            else
                gen_span(1'b0, pick_span(mdl_cfg.pause_length_ms,
                                         mdl_cfg.pause_tolerance_ms), 2);
        end
    endtask

    // Silence around the timeout, sampled a few times
    task automatic gen_silence();
        logic [TIME_W-1:0] dur;
        if ($urandom_range(0, 3) == 0)
            dur = $urandom_range(mdl_cfg.quiet_limit_ms, 0);
        else
            dur = mdl_cfg.quiet_limit_ms + $urandom_range(1, 60);
        gen_span(1'b0, dur, 3);
    endtask

    // Mostly full beep cycles, the rest silence, noise and lone spans
    task automatic run_patterns(input int unsigned count);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                gen_cycle();
            else if (roll < 86)
                gen_silence();
            else if (roll < 93)
                repeat ($urandom_range(1, 4))
                    send_sample(1'($urandom_range(0, 1)), $urandom());
            else
                gen_span(1'($urandom_range(0, 1)),
                         pick_span(mdl_cfg.beep_length_ms, mdl_cfg.beep_tolerance_ms), 2);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Window edges, bad beep, bad gap, bad pause and timestamp extremes
    task automatic test_directed();
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd100);
        send_sample(1'b0, 32'd450);      // beep at lower edge
        send_sample(1'b1, 32'd1100);     // gap at upper edge
        send_sample(1'b0, 32'd1750);     // beep at upper edge
        send_sample(1'b1, 32'd2100);     // gap at lower edge
        send_sample(1'b0, 32'd2600);     // third beep, into pause
        send_sample(1'b1, 32'd3800);     // pause at lower edge confirms a cycle
        send_sample(1'b0, 32'd4149);     // beep one short: restart
        send_sample(1'b1, 32'd4200);
        send_sample(1'b0, 32'd4700);
        send_sample(1'b1, 32'd5351);     // gap one long: restart with a fresh beep
        send_sample(1'b0, 32'd5851);
        send_sample(1'b1, 32'd6351);
        send_sample(1'b0, 32'd6851);
        send_sample(1'b1, 32'd7351);
        send_sample(1'b0, 32'd7851);
        send_sample(1'b1, 32'd9652);     // pause one long: restart
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'd0);        // wrapped timestamp
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'd0);
        now_ms = 32'd20000;
    endtask

    task automatic test_default_patterns();
        run_patterns(180);
    endtask

    // Zero-width windows and a zero timeout
    task automatic test_zero_windows();
        cfg_t c;
        c = '0;
        c.cycles_needed = 4'd1;
        apply_config(c);
        run_patterns(120);
    endtask

    // Widest windows, all-ones cycle register, count runs into saturation
    task automatic test_saturation();
        cfg_t c;
        c = '1;
        apply_config(c);
        only_good = 1'b1;
        repeat (18) gen_cycle();
        only_good = 1'b0;
        gen_span(1'b0, 32'd70000, 3);
        send_sample(1'b0, now_ms);
        run_patterns(60);
    endtask

    // Timestamps that wrap through zero
    task automatic test_wrapping_time();
        apply_config(random_config(1'b0));
        now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        run_patterns(160);
    endtask

    // Cycle register written as zero: the first good cycle detects
    task automatic test_zero_cycles_needed();
        cfg_t c;
        c = default_config();
        c.cycles_needed = '0;
        apply_config(c);
        run_patterns(150);
    endtask

    // Short timeout, detection on the first good cycle, silences clear it
    task automatic test_silence_timeout();
        cfg_t c;
        c = default_config();
        c.cycles_needed  = 4'd1;
        c.quiet_limit_ms = 16'd2200;
        apply_config(c);
        repeat (6)
        begin
            only_good = 1'b1;
            repeat (2) gen_cycle();
            only_good = 1'b0;
            gen_silence();
        end
        run_patterns(60);
    endtask

    task automatic test_random_settings();
        apply_config(random_config(1'b1));
        run_patterns(100);
        repeat (2)
        begin
            apply_config(random_config(1'b0));
            run_patterns(120);
        end
    endtask

    // Hold off results for a long stretch while samples keep coming
    task automatic test_backpressure();
        apply_config(default_config());
        src_gaps_on  = 1'b0;
        hold_request = LONG_HOLD;
        run_patterns(80);
        src_gaps_on  = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        apply_config(random_config(1'b0));
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        run_patterns(160);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_default_patterns();
        test_zero_windows();
        test_saturation();
        test_wrapping_time();
        test_zero_cycles_needed();
        test_silence_timeout();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        wait_drained();

        $display("Checked %0d status results from %0d samples over %0d register settings.",
                 results_checked, samples_sent, settings_used);
        $display("Saw %0d detections, %0d silence clears, %0d samples at a saturated count.",
                 detect_events, silence_clears, saturated_steps);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
